/* design/sprq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies; used by sprq_cell, sorted_priority_queue and the testbench.
package sprq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic        [STAT_W-1:0] status;
        logic        [OCC_W-1:0]  occupancy;
        logic signed [DATA_W-1:0] top_value;
    } rsp_t;

    // One stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t ins;
    } cmd_t;

endpackage

/* design/sprq_cell.sv */
// One slot of the sorted queue chain: holds an entry and shifts with neighbors.
// Depends on sprq_pkg.
module sprq_cell
(
    input  logic            clk,
    input  sprq_pkg::cmd_t  cmd,
    input  logic            occupied,
    input  logic            cand_left,
    input  sprq_pkg::entry_t left_entry,
    input  sprq_pkg::entry_t right_entry,
    output logic            cand,
    output sprq_pkg::entry_t entry
);

    sprq_pkg::entry_t entry_reg;
    sprq_pkg::entry_t entry_next;

    // New entry lands at or above this slot: slot empty or holds a lower priority.
    // Equal priorities stay ahead so the older one leaves first.
    assign cand  = !occupied || (entry_reg.prio < cmd.ins.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.push)
        begin
            if (cand_left)
            begin
                entry_next = left_entry;
            end
            else if (cand)
            begin
                entry_next = cmd.ins;
            end
        end
        else if (cmd.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* design/sorted_priority_queue.sv */
// Sorted priority queue: a chain of DEPTH cells, cell 0 holds the top entry.
// The response is registered in the cycle after the request is accepted.
// Throughput: one transaction per cycle while responses are taken; every cell
// compares in parallel and shifts with its neighbor in the same cycle.
// Reset: rst_n asynchronous, clears the entry count and the response valid;
// cell contents are not reset and are only read below the count.
module sorted_priority_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  sprq_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output sprq_pkg::rsp_t  rsp
);

    localparam int DEPTH  = sprq_pkg::DEPTH;
    localparam int CNT_W  = sprq_pkg::CNT_W;

    // Control state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    sprq_pkg::rsp_t   rsp_reg;
    sprq_pkg::rsp_t   rsp_next;

    // Chain wiring; the extra entry past the end feeds the last cell on a pop
    sprq_pkg::entry_t ent_w  [DEPTH+1];
    logic             cand_w [DEPTH+1];
    sprq_pkg::cmd_t   cmd;

    logic accept;
    logic is_pop;
    logic full;
    logic empty;
    logic push_ok;
    logic pop_ok;

    // Response register parts the two sides; a new transaction is accepted
    // in the same cycle a waiting result is taken.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign is_pop    = (req.kind == sprq_pkg::KIND_POP);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign push_ok   = accept && !is_pop && !full;
    assign pop_ok    = accept && is_pop && !empty;

    assign cmd.push      = push_ok;
    assign cmd.pop       = pop_ok;
    assign cmd.ins.value = req.value;
    assign cmd.ins.prio  = req.priority_req;

    assign cand_w[0]     = 1'b0;
    assign ent_w[DEPTH]  = ent_w[DEPTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            sprq_pkg::entry_t left_entry;
            if (gi == 0)
            begin : g_first
                assign left_entry = ent_w[0];
            end
            else
            begin : g_rest
                assign left_entry = ent_w[gi-1];
            end

            sprq_cell u_cell
            (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (count_reg > CNT_W'(gi)),
                .cand_left   (cand_w[gi]),
                .left_entry  (left_entry),
                .right_entry (ent_w[gi+1]),
                .cand        (cand_w[gi+1]),
                .entry       (ent_w[gi])
            );
        end
    endgenerate

    // Entry count and response contents
    always_comb
    begin
        count_next          = count_reg;
        rsp_next            = rsp_reg;
        rsp_valid_next      = rsp_valid_reg;

        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (push_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        if (accept)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.popped_value = '0;
            rsp_next.status       = sprq_pkg::ST_OK;
            rsp_next.top_value    = '0;
            rsp_next.occupancy    = sprq_pkg::OCC_W'(count_next);

            if (!is_pop)
            begin
                if (full)
                begin
                    rsp_next.status    = sprq_pkg::ST_FULL;
                    rsp_next.top_value = ent_w[0].value;
                end
                else if (cand_w[1])
                begin
                    // new entry becomes the top (also covers an empty queue)
                    rsp_next.top_value = req.value;
                end
                else
                begin
                    rsp_next.top_value = ent_w[0].value;
                end
            end
            else
            begin
                if (empty)
                begin
                    rsp_next.status = sprq_pkg::ST_EMPTY;
                end
                else
                begin
                    rsp_next.popped_value = ent_w[0].value;
                    if (count_reg > CNT_W'(1))
                    begin
                        rsp_next.top_value = ent_w[1].value;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* dv/tb_sorted_priority_queue.sv */
// Self-checking testbench for sorted_priority_queue: directed table, then random push/pop.
// Responses are checked against an in-bench shadow of the sorted queue.
// Depends on sprq_pkg and the sorted_priority_queue RTL.
module tb_sorted_priority_queue;

    localparam int RAND_TXNS  = 1530;   // random part after the directed table
    localparam int IDLE_PCT   = 19;     // chance of an idle/stall cycle per side
    localparam int CALM_FIRST = 600;    // random transactions in [CALM_FIRST, CALM_LAST)
    localparam int CALM_LAST  = 850;    // run with no idling on either side
    localparam int DRAIN_WAIT = 8;      // extra cycles after the last response

    // Random phases steer the occupancy around the whole range
    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NEAR_FULL} mix_mode_t;

    // One row of the directed table; typed-in expectation only where obvious
    typedef struct {
        sprq_pkg::req_t req;
        bit             typed;
        sprq_pkg::rsp_t want;
    } stim_row_t;

    logic           clk       = 1'b0;
    logic           rst_n;
    logic           req_valid = 1'b0;
    logic           req_ready;
    sprq_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    sprq_pkg::rsp_t rsp;

    // Typed-in expectation travels with the request it belongs to
    bit             row_typed  = 1'b0;
    sprq_pkg::rsp_t row_expect = '0;

    bit   calm       = 1'b0;
    int   fail_count = 0;

    // Shadow copy of the queue contents, sorted by ascending priority
    logic signed [sprq_pkg::DATA_W-1:0] shadow_val  [sprq_pkg::DEPTH];
    logic signed [sprq_pkg::DATA_W-1:0] shadow_prio [sprq_pkg::DEPTH];
    int                                 shadow_count = 0;

    sprq_pkg::rsp_t pending_rsp [$];
    stim_row_t      dir_rows    [$];

    sorted_priority_queue dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Apply one transaction to the shadow queue and return the response it must produce.
    // A push goes in front of the first entry whose priority is >= its own, so a newer
    // entry of equal priority sits below the older ones and the older one leaves first.
    function automatic sprq_pkg::rsp_t queue_step(sprq_pkg::req_t r);
        sprq_pkg::rsp_t o;
        int             pos;
        int             i;
        o        = '0;
        o.status = sprq_pkg::ST_OK;
        if (r.kind == sprq_pkg::KIND_PUSH)
        begin
            if (shadow_count >= sprq_pkg::DEPTH)
            begin
                o.status = sprq_pkg::ST_FULL;
            end
            else
            begin
                pos = shadow_count;
                for (i = shadow_count - 1; i >= 0; i--)
                begin
                    if ($signed(r.priority_req) <= $signed(shadow_prio[i]))
                        pos = i;
                end
                for (i = shadow_count; i > pos; i--)
                begin
                    shadow_val[i]  = shadow_val[i-1];
                    shadow_prio[i] = shadow_prio[i-1];
                end
                shadow_val[pos]  = r.value;
                shadow_prio[pos] = r.priority_req;
                shadow_count++;
            end
        end
        else
        begin
            // Highest priority lives in the last occupied slot
            if (shadow_count == 0)
            begin
                o.status = sprq_pkg::ST_EMPTY;
            end
            else
            begin
                shadow_count--;
                o.popped_value = shadow_val[shadow_count];
            end
        end
        if (shadow_count > 0)
            o.top_value = shadow_val[shadow_count-1];
        o.occupancy = sprq_pkg::OCC_W'(shadow_count);
        return o;
    endfunction

    function automatic sprq_pkg::rsp_t make_rsp(logic [sprq_pkg::DATA_W-1:0] popped,
                                                logic [sprq_pkg::STAT_W-1:0] st,
                                                logic [sprq_pkg::OCC_W-1:0]  occ,
                                                logic [sprq_pkg::DATA_W-1:0] top);
        sprq_pkg::rsp_t o;
        o.popped_value = popped;
        o.status       = st;
        o.occupancy    = occ;
        o.top_value    = top;
        return o;
    endfunction

    task automatic add_row(logic kind, logic [sprq_pkg::DATA_W-1:0] v,
                           logic [sprq_pkg::DATA_W-1:0] p,
                           bit typed, sprq_pkg::rsp_t want);
        stim_row_t row;
        row.req.kind         = kind;
        row.req.value        = v;
        row.req.priority_req = p;
        row.typed            = typed;
        row.want             = want;
        dir_rows.push_back(row);
    endtask

    task automatic check_field(string name, logic [sprq_pkg::DATA_W-1:0] want,
                               logic [sprq_pkg::DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    function automatic bit idle_roll();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Present one transaction and hold it until the DUT takes it. Valid is only
    // dropped for idle cycles, never lowered and raised within the same edge.
    task automatic drive_req(sprq_pkg::req_t r, bit typed, sprq_pkg::rsp_t want);
        while (idle_roll())
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req        <= r;
        row_typed  <= typed;
        row_expect <= want;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Random priority: mostly a narrow band so duplicates and ties are common,
    // plus full-range words and the signed extremes.
    function automatic logic [sprq_pkg::DATA_W-1:0] rand_prio();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return sprq_pkg::DATA_W'($urandom_range(0, 6) - 3);
        else if (pick < 85)
            return $urandom();
        else
        begin
            case ($urandom_range(0, 5))
                0:       return 32'h8000_0000;
                1:       return 32'h8000_0001;
                2:       return 32'h7FFF_FFFF;
                3:       return 32'h7FFF_FFFE;
                4:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
    endfunction

    // Sink side: random stalls, none during the calm stretch
    always @(posedge clk)
        rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // Scoreboard: predict on request acceptance first, then check any response
    // taken at the same edge (the oldest expectation is always the one due).
    always @(posedge clk)
    begin
        sprq_pkg::rsp_t want;
        if (rst_n && req_valid && req_ready)
        begin
            want = queue_step(req);
            if (row_typed)
                want = row_expect;
            pending_rsp.push_back(want);
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response transaction %h", $time, rsp);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("popped_value", want.popped_value, rsp.popped_value);
                check_field("status", sprq_pkg::DATA_W'(want.status),
                            sprq_pkg::DATA_W'(rsp.status));
                check_field("occupancy", sprq_pkg::DATA_W'(want.occupancy),
                            sprq_pkg::DATA_W'(rsp.occupancy));
                check_field("top_value", want.top_value, rsp.top_value);
            end
        end
    end

    initial
    begin
        sprq_pkg::req_t r;
        mix_mode_t      mode;
        int             push_pct;
        int             n;

        rst_n    <= 1'b0;
        mode     = MODE_FILL;
        push_pct = 50;

        // Directed table. Queue empties on reset, so the first pop is rejected.
        add_row(sprq_pkg::KIND_POP,  32'h0000_0000, 32'h0000_0000, 1'b1,
                make_rsp(32'h0, sprq_pkg::ST_EMPTY, 5'd0, 32'h0));
        add_row(sprq_pkg::KIND_PUSH, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                make_rsp(32'h0, sprq_pkg::ST_OK, 5'd1, 32'h7FFF_FFFF));
        add_row(sprq_pkg::KIND_PUSH, 32'h8000_0000, 32'h8000_0000, 1'b0, '0);
        // Equal top priority: the older entry must still leave first
        add_row(sprq_pkg::KIND_PUSH, 32'h1234_5678, 32'h7FFF_FFFF, 1'b0, '0);
        add_row(sprq_pkg::KIND_POP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
        // Fill to capacity with ties, extremes and mid values
        add_row(sprq_pkg::KIND_PUSH, 32'hA5A5_A5A5, 32'h0000_0000, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'h0000_0001, 32'h0000_0001, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'h0000_0002, 32'h0000_0000, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'h0000_0003, 32'h8000_0001, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'h0000_0004, 32'h8000_0000, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'h0000_0005, 32'h7FFF_FFFE, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'h0000_0006, 32'h7FFF_FFFF, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'hFFFF_FFFF, 32'h0000_0064, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'h8000_0000, 32'hFFFF_FF9C, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'h7FFF_FFFF, 32'h0000_0064, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'h0000_0000, 32'h0000_0000, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 1'b0, '0);
        add_row(sprq_pkg::KIND_PUSH, 32'hCAFE_F00D, 32'h0000_0037, 1'b0, '0);
        // Full: rejected, the oldest max-priority entry stays on top
        add_row(sprq_pkg::KIND_PUSH, 32'h1111_1111, 32'h7FFF_FFFF, 1'b1,
                make_rsp(32'h0, sprq_pkg::ST_FULL, 5'd16, 32'h1234_5678));
        add_row(sprq_pkg::KIND_POP,  32'h0000_0000, 32'h0000_0000, 1'b0, '0);
        add_row(sprq_pkg::KIND_POP,  32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '0);
        // Push at the maximum priority: it lands behind the older equal entry
        add_row(sprq_pkg::KIND_PUSH, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            drive_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        // Random part: phases bias push/pop so occupancy sweeps empty..full
        for (n = 0; n < RAND_TXNS; n++)
        begin
            if (n % 60 == 0)
            begin
                mode = mix_mode_t'($urandom_range(0, 3));
                case (mode)
                    MODE_FILL:  push_pct = 80;
                    MODE_DRAIN: push_pct = 20;
                    MODE_MIXED: push_pct = 50;
                    default:    push_pct = 58;
                endcase
            end
            calm = (n >= CALM_FIRST) && (n < CALM_LAST);
            r.kind         = ($urandom_range(0, 99) < push_pct) ? sprq_pkg::KIND_PUSH
                                                                : sprq_pkg::KIND_POP;
            r.value        = $urandom();
            r.priority_req = rand_prio();
            drive_req(r, 1'b0, '0);
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("** sorted_priority_queue: PASSED **");
        else
            $display("** sorted_priority_queue: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("** sorted_priority_queue: FAILED **");
        $finish;
    end

endmodule
